/* src/swcf_pkg.sv */
// ----------------------------------------------------------------------------
// swcf_pkg: shared types and functions for the sensor word CRC framer
// Codes for the byte mode and the result kind, the CRC-8 byte update, and
// the structs that pass the word state and result groups between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package swcf_pkg;

  // Byte modes
  localparam logic [1:0] MODE_HEADER = 2'd0;
  localparam logic [1:0] MODE_FRAME  = 2'd1;
  localparam logic [1:0] MODE_CHECK  = 2'd2;

  // Result kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_WORD = 1'b1;

  // CRC-8 settings, MSB first, no final XOR
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Word position codes
  localparam logic [1:0] POS_START  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_CRC    = 2'd2;

  // Most results one item can cause
  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic [1:0] word_position;
    logic [7:0] running_crc;
    logic [7:0] held_byte;
    logic [7:0] held_second;
    logic       failed_flag;
  } word_state_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic [15:0] out_word;
    logic        crc_ok;
    logic        message_failed;
    logic        run_end;
  } result_t;

  typedef struct packed {
    logic [1:0]                     count;
    result_t [MaxResults-1:0]       res;
  } result_grp_t;

  localparam word_state_t STATE_RESET = '{
    word_position: POS_START,
    running_crc:   CRC_INIT,
    held_byte:     8'h00,
    held_second:   8'h00,
    failed_flag:   1'b0
  };

  // One byte through the CRC-8 register, bit by bit
  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  // Byte result: framed byte, flags clear
  function automatic result_t byte_result(input logic [7:0] b, input logic run_end);
    result_t r;
    r = '0;
    r.kind     = KIND_BYTE;
    r.out_byte = b;
    r.run_end  = run_end;
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/swcf_if.sv */
// ----------------------------------------------------------------------------
// swcf_if: item channels of the sensor word CRC framer
// Valid/ready channels; an item moves at a clock edge with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface swcf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  logic       first;
  logic       last;

  modport source (output valid, mode, data_byte, first, last, input ready);
  modport sink   (input valid, mode, data_byte, first, last, output ready);
endinterface

interface swcf_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  out_byte;
  logic [15:0] out_word;
  logic        crc_ok;
  logic        message_failed;
  logic        run_end;

  modport source (output valid, kind, out_byte, out_word, crc_ok, message_failed, run_end,
                  input ready);
  modport sink   (input valid, kind, out_byte, out_word, crc_ok, message_failed, run_end,
                  output ready);
endinterface

`default_nettype wire

/* src/swcf_step.sv */
// ----------------------------------------------------------------------------
// swcf_step: per-item framing and checking logic
// From the word state and one input item, works out the next word state and
// the group of up to three results the item causes.
// ----------------------------------------------------------------------------
`default_nettype none

module swcf_step (
  input  swcf_pkg::word_state_t state_i,
  input  logic [1:0]            mode_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  first_i,
  input  logic                  last_i,
  output swcf_pkg::word_state_t state_o,
  output swcf_pkg::result_grp_t grp_o
);

  swcf_pkg::word_state_t cur;
  logic [7:0]            crc_start;
  logic [7:0]            crc_next;
  logic [7:0]            crc_pad;
  logic                  crc_match;
  logic                  fail_next;

  // first clears the word state ahead of this byte
  assign cur = first_i ? swcf_pkg::STATE_RESET : state_i;

  // A new word starts from the init value, a second byte continues
  assign crc_start = (cur.word_position == swcf_pkg::POS_SECOND) ? cur.running_crc
                                                                 : swcf_pkg::CRC_INIT;
  assign crc_next  = swcf_pkg::crc_update(crc_start, data_byte_i);
  assign crc_pad   = swcf_pkg::crc_update(crc_next, 8'h00);
  assign crc_match = (data_byte_i == cur.running_crc);
  assign fail_next = cur.failed_flag | ~crc_match;

  always_comb begin
    state_o = cur;
    grp_o   = '0;
    case (mode_i)
      swcf_pkg::MODE_HEADER: begin
        grp_o.count  = 2'd1;
        grp_o.res[0] = swcf_pkg::byte_result(data_byte_i, 1'b1);
      end
      swcf_pkg::MODE_FRAME: begin
        if (cur.word_position != swcf_pkg::POS_SECOND) begin
          if (last_i) begin
            // odd final byte: zero pad, then CRC over byte and pad
            grp_o.count  = 2'd3;
            grp_o.res[0] = swcf_pkg::byte_result(data_byte_i, 1'b0);
            grp_o.res[1] = swcf_pkg::byte_result(8'h00, 1'b0);
            grp_o.res[2] = swcf_pkg::byte_result(crc_pad, 1'b1);
            state_o.word_position = swcf_pkg::POS_START;
            state_o.running_crc   = swcf_pkg::CRC_INIT;
          end else begin
            grp_o.count  = 2'd1;
            grp_o.res[0] = swcf_pkg::byte_result(data_byte_i, 1'b1);
            state_o.word_position = swcf_pkg::POS_SECOND;
            state_o.running_crc   = crc_next;
          end
        end else begin
          grp_o.count  = 2'd2;
          grp_o.res[0] = swcf_pkg::byte_result(data_byte_i, 1'b0);
          grp_o.res[1] = swcf_pkg::byte_result(crc_next, 1'b1);
          state_o.word_position = swcf_pkg::POS_START;
          state_o.running_crc   = swcf_pkg::CRC_INIT;
        end
      end
      swcf_pkg::MODE_CHECK: begin
        if (cur.word_position == swcf_pkg::POS_SECOND) begin
          state_o.held_second   = data_byte_i;
          state_o.running_crc   = crc_next;
          state_o.word_position = swcf_pkg::POS_CRC;
        end else if (cur.word_position == swcf_pkg::POS_CRC) begin
          // third byte: compare and emit the word
          grp_o.count                 = 2'd1;
          grp_o.res[0].kind           = swcf_pkg::KIND_WORD;
          grp_o.res[0].out_word       = {cur.held_byte, cur.held_second};
          grp_o.res[0].crc_ok         = crc_match;
          grp_o.res[0].message_failed = fail_next;
          grp_o.res[0].run_end        = 1'b1;
          state_o.failed_flag         = fail_next;
          state_o.word_position       = swcf_pkg::POS_START;
          state_o.running_crc         = swcf_pkg::CRC_INIT;
        end else begin
          state_o.held_byte     = data_byte_i;
          state_o.running_crc   = crc_next;
          state_o.word_position = swcf_pkg::POS_SECOND;
        end
      end
      default: begin
        // no result; only first and last act
      end
    endcase

    // end of message drops any partial word
    if (last_i) begin
      state_o.word_position = swcf_pkg::POS_START;
      state_o.running_crc   = swcf_pkg::CRC_INIT;
    end
  end

endmodule

`default_nettype wire

/* src/sensor_word_crc_framer.sv */
// ----------------------------------------------------------------------------
// sensor_word_crc_framer: CRC-8 framer and checker for sensor bus words
// Frames parameter bytes with CRC-8 (poly 0x31, init 0xFF) and checks
// received words, passing header bytes through.
// ----------------------------------------------------------------------------
// Each item is registered on input, handled by the combinational step logic,
// and its results are held in a result register and sent one per cycle while
// the output is ready. A header byte, a checked word or a frame byte that
// opens a word causes one result; a frame byte that closes a word causes two,
// and an odd final frame byte three. A partial received word or an unused
// mode causes none. An item that causes one result goes through at one item
// per cycle while the output is ready; an item with two or three results holds
// the output port until all are sent, which sets the sustained rate. An item
// passes the input register, then the result register. A new item is taken
// into the input register while earlier results still wait on the output.
`default_nettype none

module sensor_word_crc_framer (
  input  logic             clk_i,
  input  logic             rst_ni,
  swcf_in_if.sink          in_i,
  swcf_out_if.source       out_o
);

  // Input register
  logic       in_vld_q;
  logic [1:0] mode_q;
  logic [7:0] data_byte_q;
  logic       first_q;
  logic       last_q;

  // Word state and result register
  swcf_pkg::word_state_t state_q, state_d;
  swcf_pkg::result_grp_t grp_q, grp_d;
  logic [1:0]            cnt_q;
  logic [1:0]            idx_q;

  logic in_take;
  logic out_take;
  logic grp_free;
  logic move;
  swcf_pkg::result_t cur_res;

  swcf_step u_step (
    .state_i     (state_q),
    .mode_i      (mode_q),
    .data_byte_i (data_byte_q),
    .first_i     (first_q),
    .last_i      (last_q),
    .state_o     (state_d),
    .grp_o       (grp_d)
  );

  // Handshakes
  assign out_take = out_o.valid & out_o.ready;
  assign grp_free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);
  assign move     = in_vld_q & grp_free;
  assign in_i.ready = ~in_vld_q | move;
  assign in_take  = in_i.valid & in_i.ready;

  // Output from the result register
  assign cur_res              = grp_q.res[idx_q];
  assign out_o.valid          = (cnt_q != 2'd0);
  assign out_o.kind           = cur_res.kind;
  assign out_o.out_byte       = cur_res.out_byte;
  assign out_o.out_word       = cur_res.out_word;
  assign out_o.crc_ok         = cur_res.crc_ok;
  assign out_o.message_failed = cur_res.message_failed;
  assign out_o.run_end        = cur_res.run_end;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      cnt_q    <= 2'd0;
      idx_q    <= 2'd0;
      state_q  <= swcf_pkg::STATE_RESET;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (move) begin
        in_vld_q <= 1'b0;
      end

      if (move) begin
        cnt_q   <= grp_d.count;
        idx_q   <= 2'd0;
        state_q <= state_d;
      end else if (out_take) begin
        cnt_q <= cnt_q - 2'd1;
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q      <= in_i.mode;
      data_byte_q <= in_i.data_byte;
      first_q     <= in_i.first;
      last_q      <= in_i.last;
    end
    if (move) begin
      grp_q <= grp_d;
    end
  end

endmodule

`default_nettype wire
